### src/mrdp_pkg.sv
// shared types and constants for the matrix row dot product core
// no dependencies; imported by every module of the block
package mrdp_pkg;

    // input item kinds
    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_VECTOR = 2'd2
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_RANGE  = 2'd1,
        STATUS_LENGTH = 2'd2
    } status_t;

    // operations handed from front to back
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_VECTOR = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_ROW_COUNT    = 1'b0,
        REG_COLUMN_COUNT = 1'b1
    } reg_index_t;

    localparam int DIM_W    = 8;
    localparam int COUNT_W  = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
    localparam int ENTRY_W  = 16;
    localparam int ELEM_W   = 32;
    localparam int PROD_W   = ENTRY_W + ELEM_W;
    localparam int ACC_W    = 64;
    localparam int RATE_W   = 56;

    // classified command; hit is in-range for read/write, accumulate enable for vector
    typedef struct packed {
        op_t                  op;
        logic                 hit;
        logic                 first;
        logic                 last;
        status_t              status;
        logic [ENTRY_W-1:0]   value;
        logic [ELEM_W-1:0]    elem;
    } cmd_t;

endpackage

### src/mrdp_front.sv
// front end: configuration registers, run tracking, item classification
// and store address computation; depends on mrdp_pkg
module mrdp_front
    import mrdp_pkg::*;
#(
    parameter int ROW_LIMIT    = 256,
    parameter int COLUMN_LIMIT = 256,
    parameter int ADDR_W       = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [0:0]               cfg_index,
    input  logic [DIM_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               kind,
    input  logic [DIM_W-1:0]         row,
    input  logic [DIM_W-1:0]         column,
    input  logic signed [ENTRY_W-1:0] entry_value,
    input  logic signed [ELEM_W-1:0] vector_element,
    input  logic                     last,
    input  logic                     clear_busy,
    input  logic                     q_full,
    output logic                     push,
    output cmd_t                     push_cmd,
    output logic [ADDR_W-1:0]        push_addr
);

    logic [DIM_W-1:0]   row_count_reg;
    logic [DIM_W-1:0]   column_count_reg;
    logic               run_active_reg;
    logic [DIM_W-1:0]   run_row_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               accept;
    logic               in_range;
    logic [DIM_W-1:0]   run_row_eff;
    logic [COUNT_W-1:0] count_eff;
    logic [COUNT_W-1:0] count_after;
    logic               acc_en;
    status_t            run_status;
    logic [DIM_W-1:0]   mul_row;
    logic [DIM_W-1:0]   mul_col;
    logic [2*DIM_W-1:0] lin_addr;

    assign in_stall = clear_busy || q_full;
    assign accept   = in_valid && !in_stall;

    // configuration writes, out-of-limit values are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= '0;
            column_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ROW_COUNT:
                begin
                    if (32'(cfg_data) < ROW_LIMIT)
                        row_count_reg <= cfg_data;
                end
                REG_COLUMN_COUNT:
                begin
                    if (32'(cfg_data) < COLUMN_LIMIT)
                        column_count_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // run view as seen by the current vector element
    always_comb
    begin
        in_range    = (row < row_count_reg) && (column < column_count_reg);
        run_row_eff = run_active_reg ? run_row_reg : row;
        count_eff   = run_active_reg ? count_reg : '0;
        acc_en      = (run_row_eff < row_count_reg)
                      && (count_eff < {1'b0, column_count_reg});
        count_after = (count_eff < COUNT_MAX) ? count_eff + 1'b1 : count_eff;
        if (run_row_eff >= row_count_reg)
            run_status = STATUS_RANGE;
        else if (count_after != {1'b0, column_count_reg})
            run_status = STATUS_LENGTH;
        else
            run_status = STATUS_OK;
    end

    // row-major address, one shared multiplier
    always_comb
    begin
        mul_row   = (kind == KIND_VECTOR) ? run_row_eff : row;
        mul_col   = (kind == KIND_VECTOR) ? count_eff[DIM_W-1:0] : column;
        lin_addr  = {{DIM_W{1'b0}}, mul_row} * {{DIM_W{1'b0}}, column_count_reg}
                    + {{DIM_W{1'b0}}, mul_col};
        push_addr = ADDR_W'(lin_addr);
    end

    // classify the item into a back-end command
    always_comb
    begin
        push_cmd        = '0;
        push_cmd.value  = entry_value;
        push_cmd.elem   = vector_element;
        push_cmd.status = STATUS_OK;
        push            = 1'b0;
        case (kind)
            KIND_WRITE:
            begin
                push_cmd.op  = OP_WRITE;
                push_cmd.hit = in_range;
                push         = accept && in_range;
            end
            KIND_READ:
            begin
                push_cmd.op     = OP_READ;
                push_cmd.hit    = in_range;
                push_cmd.status = in_range ? STATUS_OK : STATUS_RANGE;
                push            = accept;
            end
            KIND_VECTOR:
            begin
                push_cmd.op     = OP_VECTOR;
                push_cmd.hit    = acc_en;
                push_cmd.first  = !run_active_reg;
                push_cmd.last   = last;
                push_cmd.status = run_status;
                push            = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // run state update on each accepted vector element
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg <= 1'b0;
            run_row_reg    <= '0;
            count_reg      <= '0;
        end
        else if (accept && (kind == KIND_VECTOR))
        begin
            run_active_reg <= !last;
            run_row_reg    <= run_row_eff;
            count_reg      <= count_after;
        end
    end

endmodule

### src/mrdp_queue.sv
// short command queue between front end and back end
// depends on mrdp_pkg for the command type
module mrdp_queue
    import mrdp_pkg::*;
#(
    parameter int DEPTH  = 4,
    parameter int ADDR_W = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cmd_t              push_cmd,
    input  logic [ADDR_W-1:0] push_addr,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output cmd_t              head_cmd,
    output logic [ADDR_W-1:0] head_addr
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t              cmd_q [DEPTH];
    logic [ADDR_W-1:0] addr_q [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;
    assign head_cmd   = cmd_q[rd_ptr_reg];
    assign head_addr  = addr_q[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_q[wr_ptr_reg]  <= push_cmd;
            addr_q[wr_ptr_reg] <= push_addr;
        end
    end

    // front end never pushes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    // fill count stays within depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count overflow");

endmodule

### src/mrdp_back.sv
// back end: matrix store with clearing pass, multiply-accumulate pipeline
// and output register; depends on mrdp_pkg
module mrdp_back
    import mrdp_pkg::*;
#(
    parameter int STORE_DEPTH = 65536,
    parameter int ADDR_W      = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  cmd_t                      q_cmd,
    input  logic [ADDR_W-1:0]         q_addr,
    output logic                      pop,
    output logic                      clear_busy,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [ENTRY_W-1:0] read_value,
    output logic signed [RATE_W-1:0]  rate,
    output logic [1:0]                status
);

    logic [ENTRY_W-1:0]       store_mem [STORE_DEPTH];
    logic                     clear_busy_reg;
    logic [ADDR_W-1:0]        clear_addr_reg;
    logic                     advance;

    logic                     s1_valid_reg;
    cmd_t                     s1_cmd_reg;
    logic signed [ENTRY_W-1:0] rdata_reg;

    logic                     s2_valid_reg;
    cmd_t                     s2_cmd_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic [ENTRY_W-1:0]       s2_read_reg;
    logic signed [PROD_W-1:0] s1_prod;

    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     out_valid_reg, out_valid_next;
    logic [ENTRY_W-1:0]       read_value_reg;
    logic [RATE_W-1:0]        rate_reg;
    status_t                  status_reg;

    assign clear_busy = clear_busy_reg;
    assign advance    = !out_valid_reg || !out_stall;
    assign pop        = q_valid && advance && !clear_busy_reg;

    // clearing pass over the store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                clear_busy_reg <= 1'b0;
        end
    end

    // store port: at most one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (clear_busy_reg)
            store_mem[clear_addr_reg] <= '0;
        else if (pop && (q_cmd.op == OP_WRITE))
            store_mem[q_addr] <= q_cmd.value;
        if (pop)
            rdata_reg <= store_mem[q_addr];
    end

    // stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= pop;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            s1_cmd_reg <= q_cmd;
    end

    // stage two: entry times element
    assign s1_prod = PROD_W'($signed(s1_cmd_reg.elem)) * PROD_W'(rdata_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            s2_cmd_reg  <= s1_cmd_reg;
            s2_prod_reg <= (s1_cmd_reg.op == OP_VECTOR && s1_cmd_reg.hit) ? s1_prod : '0;
            s2_read_reg <= (s1_cmd_reg.op == OP_READ && s1_cmd_reg.hit) ? rdata_reg : '0;
        end
    end

    // accumulate and result selection
    always_comb
    begin
        acc_next = (s2_cmd_reg.first ? '0 : acc_reg)
                   + {{(ACC_W-PROD_W){s2_prod_reg[PROD_W-1]}}, s2_prod_reg};
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = s2_valid_reg
                             && ((s2_cmd_reg.op == OP_READ)
                                 || (s2_cmd_reg.op == OP_VECTOR && s2_cmd_reg.last));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance && s2_valid_reg && (s2_cmd_reg.op == OP_VECTOR))
                acc_reg <= acc_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            case (s2_cmd_reg.op)
                OP_READ:
                begin
                    read_value_reg <= s2_read_reg;
                    rate_reg       <= '0;
                    status_reg     <= s2_cmd_reg.status;
                end
                OP_VECTOR:
                begin
                    read_value_reg <= '0;
                    rate_reg       <= (s2_cmd_reg.status == STATUS_OK)
                                      ? acc_next[RATE_W-1:0] : '0;
                    status_reg     <= s2_cmd_reg.status;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign rate       = rate_reg;
    assign status     = status_reg;

endmodule

### src/matrix_row_dot_product_core.sv
// top level of the matrix row dot product core
// depends on mrdp_pkg, mrdp_front, mrdp_queue and mrdp_back

// Items stream at one per cycle while in_stall is low: each takes one store
// access and one multiply-accumulate, then passes in turn through the queue,
// store read, multiply and accumulate/output register. The front end
// classifies items and computes row-major addresses; a four-entry queue lets
// it keep accepting while the back end waits on out_stall. After reset the
// store is cleared one entry per cycle, all ROW_LIMIT * COLUMN_LIMIT entries
// (65536 at the defaults), and in_stall stays high until the pass ends;
// configuration writes are taken throughout.
module matrix_row_dot_product_core
    import mrdp_pkg::*;
#(
    parameter int ROW_LIMIT    = 256,
    parameter int COLUMN_LIMIT = 256
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [0:0]                cfg_index,
    input  logic [DIM_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                kind,
    input  logic [DIM_W-1:0]          row,
    input  logic [DIM_W-1:0]          column,
    input  logic signed [ENTRY_W-1:0] entry_value,
    input  logic signed [ELEM_W-1:0]  vector_element,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [ENTRY_W-1:0] read_value,
    output logic signed [RATE_W-1:0]  rate,
    output logic [1:0]                status
);

    localparam int STORE_DEPTH = ROW_LIMIT * COLUMN_LIMIT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int Q_DEPTH     = 4;

    logic              clear_busy;
    logic              q_full;
    logic              push;
    cmd_t              push_cmd;
    logic [ADDR_W-1:0] push_addr;
    logic              pop;
    logic              head_valid;
    cmd_t              head_cmd;
    logic [ADDR_W-1:0] head_addr;

    // item classification
    mrdp_front #(
        .ROW_LIMIT    (ROW_LIMIT),
        .COLUMN_LIMIT (COLUMN_LIMIT),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .row            (row),
        .column         (column),
        .entry_value    (entry_value),
        .vector_element (vector_element),
        .last           (last),
        .clear_busy     (clear_busy),
        .q_full         (q_full),
        .push           (push),
        .push_cmd       (push_cmd),
        .push_addr      (push_addr)
    );

    // command queue
    mrdp_queue #(
        .DEPTH  (Q_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_addr  (push_addr),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_addr  (head_addr)
    );

    // store and arithmetic
    mrdp_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (head_valid),
        .q_cmd      (head_cmd),
        .q_addr     (head_addr),
        .pop        (pop),
        .clear_busy (clear_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .rate       (rate),
        .status     (status)
    );

    // no item is taken while the store is being cleared
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> in_stall)
        else $error("item accepted during store clear");

    // error results carry zero payload
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_OK)) |-> (rate == '0 && read_value == '0))
        else $error("error result with nonzero payload");

    // a read result never carries a product
    a_read_no_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (read_value != '0)) |-> (rate == '0))
        else $error("read result with nonzero rate");

endmodule
